>>> hw/rtl/lrq_pkg.sv
// ============================================================================
// lrq_pkg: shared types and constants of the linear resampler
// Widths, register indexes and transfer payload structs used by all modules.
// ============================================================================
package lrq_pkg;

   localparam int LANES        = 8;
   localparam int MAX_CHANNELS = 8;
   localparam int FRAC_BITS    = 16;
   localparam int SAMPLE_W     = 16;
   localparam int PHASE_W      = 21;
   localparam int STEP_W       = 20;
   localparam int COUNT_W      = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 20;

   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
   localparam logic [STEP_W-1:0]  MIN_STEP  = STEP_W'(1024);

   localparam logic [STEP_W-1:0]  RESET_STEP  = STEP_W'(65536);
   localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(2);

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS        = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = CSR_INDEX_W'(2);

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type sample_0;
      sample_type sample_1;
      sample_type sample_2;
      sample_type sample_3;
      sample_type sample_4;
      sample_type sample_5;
      sample_type sample_6;
      sample_type sample_7;
   } req_data_type;

   typedef struct packed {
      sample_type out_0;
      sample_type out_1;
      sample_type out_2;
      sample_type out_3;
      sample_type out_4;
      sample_type out_5;
      sample_type out_6;
      sample_type out_7;
      logic       last_of_run;
   } rsp_data_type;

   // Controls handed to the merge stage.
   typedef struct packed {
      logic               bypass;
      logic               last;
      logic [COUNT_W-1:0] active;
   } merge_ctl_type;

endpackage

>>> hw/rtl/lrq_lane.sv
// ============================================================================
// lrq_lane: one channel of the interpolator
// Registers prev and (cur - prev) * frac, then adds, floors and saturates to 16 bits.
// ============================================================================
module lrq_lane (
   input  logic                           clock,
   input  logic                           lane_load,
   input  lrq_pkg::sample_type            prev_sample,
   input  lrq_pkg::sample_type            cur_sample,
   input  logic [lrq_pkg::FRAC_BITS-1:0]  frac,
   output lrq_pkg::sample_type            blend_out
);

   localparam int DIFF_W = lrq_pkg::SAMPLE_W + 1;
   localparam int PROD_W = DIFF_W + lrq_pkg::FRAC_BITS + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam int Q_W    = SUM_W - lrq_pkg::FRAC_BITS;

   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

   logic signed [DIFF_W-1:0]        diff;
   logic signed [lrq_pkg::FRAC_BITS:0] frac_s;
   logic signed [PROD_W-1:0]        prod_in;
   logic signed [PROD_W-1:0]        prod_ff;
   lrq_pkg::sample_type             base_ff;
   logic signed [SUM_W-1:0]         sum;
   logic signed [Q_W-1:0]           q;

   // prev*(1-f) + cur*f is rewritten as prev*ONE + (cur-prev)*f.
   assign diff    = DIFF_W'(cur_sample) - DIFF_W'(prev_sample);
   assign frac_s  = $signed({1'b0, frac});
   assign prod_in = PROD_W'(diff) * PROD_W'(frac_s);

   always_ff @(posedge clock) begin
      if (lane_load) begin
         prod_ff <= prod_in;
         base_ff <= prev_sample;
      end
   end

   assign sum = (SUM_W'(base_ff) <<< lrq_pkg::FRAC_BITS) + SUM_W'(prod_ff);
   assign q   = $signed(sum[SUM_W-1:lrq_pkg::FRAC_BITS]);

   always_comb begin
      if (q > Q_MAX) begin
         blend_out = lrq_pkg::SAMPLE_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         blend_out = lrq_pkg::SAMPLE_W'(Q_MIN);
      end else begin
         blend_out = q[lrq_pkg::SAMPLE_W-1:0];
      end
   end

endmodule

>>> hw/rtl/lrq_merge.sv
// ============================================================================
// lrq_merge: combines the lane results into one output frame
// Selects bypass or interpolated samples and zeroes the inactive lanes.
// ============================================================================
module lrq_merge (
   input  lrq_pkg::sample_type    blend_sample [lrq_pkg::LANES],
   input  lrq_pkg::sample_type    cur_sample   [lrq_pkg::LANES],
   input  lrq_pkg::merge_ctl_type ctl,
   output lrq_pkg::rsp_data_type  frame_out
);

   lrq_pkg::sample_type lane_value [lrq_pkg::LANES];

   always_comb begin
      for (int i = 0; i < lrq_pkg::LANES; i++) begin
         if (lrq_pkg::COUNT_W'(i) >= ctl.active) begin
            lane_value[i] = '0;
         end else if (ctl.bypass) begin
            lane_value[i] = cur_sample[i];
         end else begin
            lane_value[i] = blend_sample[i];
         end
      end
   end

   always_comb begin
      frame_out.out_0       = lane_value[0];
      frame_out.out_1       = lane_value[1];
      frame_out.out_2       = lane_value[2];
      frame_out.out_3       = lane_value[3];
      frame_out.out_4       = lane_value[4];
      frame_out.out_5       = lane_value[5];
      frame_out.out_6       = lane_value[6];
      frame_out.out_7       = lane_value[7];
      frame_out.last_of_run = ctl.last;
   end

endmodule

>>> hw/rtl/linear_resampler_q16_unit.sv
// ============================================================================
// linear_resampler_q16_unit: linear interpolation sample rate converter
// Converts interleaved 16-bit frames of up to eight channels between rates
// with a Q16 phase accumulator; eight lanes interpolate one frame at a time.
// ============================================================================
//
//   Channel  | Ports                              | Direction | Carries
//   ---------+------------------------------------+-----------+-------------------------
//   request  | req_valid, req_stall, req_data     | in        | one input frame
//   response | rsp_valid, rsp_stall, rsp_data     | out       | one output frame + last
//   config   | csr_write_en, csr_index, csr_write_data | in   | phase step, bypass, count
//
// Each output frame passes the sequencer states in order: the eight lane
// multipliers are registered in ST_MUL, and the add, floor and saturate
// feed the output register in ST_ADD, which waits while that register is
// stalled. A frame that yields no output only passes ST_MUL. No new input
// frame is taken until the block returns to ST_IDLE.
// Reset is synchronous and active high; it returns the configuration to
// its defaults, clears the phase and the primed flag and empties the
// output register. A new input transfer is taken while the last result of
// the previous frame still waits in the output register.
//
module linear_resampler_q16_unit (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  lrq_pkg::req_data_type              req_data,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output lrq_pkg::rsp_data_type              rsp_data,

   input  logic                               csr_write_en,
   input  logic [lrq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lrq_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an input frame
   localparam logic [1:0] ST_MUL  = 2'd1;  // lane products being registered
   localparam logic [1:0] ST_ADD  = 2'd2;  // result goes to output register

   // Configuration registers.
   logic [lrq_pkg::STEP_W-1:0]  step_ff;
   logic                        bypass_ff;
   logic [lrq_pkg::COUNT_W-1:0] count_ff;

   // Control state.
   logic [1:0]                  state_ff, state_in;
   logic [lrq_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic                        primed_ff, primed_in;

   // Frame storage.
   lrq_pkg::sample_type prev_ff [lrq_pkg::LANES];
   lrq_pkg::sample_type prev_in [lrq_pkg::LANES];
   lrq_pkg::sample_type cur_ff  [lrq_pkg::LANES];
   lrq_pkg::sample_type cur_in  [lrq_pkg::LANES];
   lrq_pkg::sample_type req_sample [lrq_pkg::LANES];
   lrq_pkg::sample_type blend_sample [lrq_pkg::LANES];

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   lrq_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   lrq_pkg::rsp_data_type merged;

   logic [lrq_pkg::STEP_W-1:0]  step_eff;
   logic [lrq_pkg::COUNT_W-1:0] active;
   logic [lrq_pkg::PHASE_W-1:0] phase_next;
   logic                        out_free;
   logic                        out_load;
   logic                        last;
   logic                        lane_load;
   lrq_pkg::merge_ctl_type      merge_ctl;

   // ------------------------------------------------------------------------
   // Configuration writes. An index beyond the register list is ignored.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= lrq_pkg::RESET_STEP;
         bypass_ff <= 1'b0;
         count_ff  <= lrq_pkg::RESET_COUNT;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lrq_pkg::CSR_PHASE_STEP: begin
               step_ff <= csr_write_data[lrq_pkg::STEP_W-1:0];
            end
            lrq_pkg::CSR_BYPASS: begin
               bypass_ff <= csr_write_data[0];
            end
            lrq_pkg::CSR_CHANNEL_COUNT: begin
               count_ff <= csr_write_data[lrq_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A step below the minimum acts as the minimum, which bounds one input
   // frame to 64 output frames. The channel count is clamped to 1..8.
   assign step_eff = (step_ff < lrq_pkg::MIN_STEP) ? lrq_pkg::MIN_STEP : step_ff;

   always_comb begin
      if (count_ff == '0) begin
         active = lrq_pkg::COUNT_W'(1);
      end else if (count_ff > lrq_pkg::COUNT_W'(lrq_pkg::MAX_CHANNELS)) begin
         active = lrq_pkg::COUNT_W'(lrq_pkg::MAX_CHANNELS);
      end else begin
         active = count_ff;
      end
   end

   // Unpack the input transfer into lanes.
   assign req_sample[0] = req_data.sample_0;
   assign req_sample[1] = req_data.sample_1;
   assign req_sample[2] = req_data.sample_2;
   assign req_sample[3] = req_data.sample_3;
   assign req_sample[4] = req_data.sample_4;
   assign req_sample[5] = req_data.sample_5;
   assign req_sample[6] = req_data.sample_6;
   assign req_sample[7] = req_data.sample_7;

   // The phase is below one whenever a blend is produced, so this sum
   // always fits in the phase width.
   assign phase_next = phase_ff + lrq_pkg::PHASE_W'(step_eff);
   assign last       = bypass_ff || (phase_next >= lrq_pkg::PHASE_ONE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign lane_load  = (state_ff == ST_MUL);
   assign req_stall  = (state_ff != ST_IDLE);

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      primed_in = primed_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      out_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_sample;
               // The first frame after reset is also its own predecessor.
               if (!primed_ff) begin
                  prev_in   = req_sample;
                  primed_in = 1'b1;
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (!bypass_ff && (phase_ff >= lrq_pkg::PHASE_ONE)) begin
               // Phase at or past one: no output; the frame moves the window and takes one off the phase.
               phase_in = phase_ff - lrq_pkg::PHASE_ONE;
               prev_in  = cur_ff;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (out_free) begin
               out_load = 1'b1;
               if (bypass_ff) begin
                  prev_in  = cur_ff;
                  state_in = ST_IDLE;
               end else if (last) begin
                  phase_in = phase_next - lrq_pkg::PHASE_ONE;
                  prev_in  = cur_ff;
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_next;
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= '0;
         primed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         primed_ff <= primed_in;
      end
   end

   // The previous frame is always written before it is read.
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
   end

   // ------------------------------------------------------------------------
   // Lanes and merge stage.
   // ------------------------------------------------------------------------
   for (genvar g = 0; g < lrq_pkg::LANES; g++) begin : g_lane
      lrq_lane u_lane (
         .clock       (clock),
         .lane_load   (lane_load),
         .prev_sample (prev_ff[g]),
         .cur_sample  (cur_ff[g]),
         .frac        (phase_ff[lrq_pkg::FRAC_BITS-1:0]),
         .blend_out   (blend_sample[g])
      );
   end

   assign merge_ctl.bypass = bypass_ff;
   assign merge_ctl.last   = last;
   assign merge_ctl.active = active;

   lrq_merge u_merge (
      .blend_sample (blend_sample),
      .cur_sample   (cur_ff),
      .ctl          (merge_ctl),
      .frame_out    (merged)
   );

   // ------------------------------------------------------------------------
   // Output register: holds a result until its transfer completes.
   // ------------------------------------------------------------------------
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = merged;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
